[hdl/ttpa_pkg.sv]
package ttpa_pkg;

    localparam int TAP_DEPTH = 32;
    localparam int IW        = $clog2(TAP_DEPTH);
    localparam int CW        = $clog2(TAP_DEPTH + 1);
    localparam int GAP_DEPTH = TAP_DEPTH - 1;
    localparam int SW        = 13 + IW;
    localparam int DIV_W     = 32;
    localparam int DIV_CW    = $clog2(DIV_W + 1);

    localparam int GAP_MIN = 100;
    localparam int GAP_MAX = 3000;
    localparam int PCT_SCALE = 100;

    localparam int MATCH_LO  = 92;
    localparam int MATCH_HI  = 108;
    localparam int X2_LO     = 190;
    localparam int X2_HI     = 210;
    localparam int H2_LO     = 45;
    localparam int H2_HI     = 55;
    localparam int X4_LO     = 380;
    localparam int X4_HI     = 420;
    localparam int H4_LO     = 22;
    localparam int H4_HI     = 28;
    localparam int T32_LO    = 140;
    localparam int T32_HI    = 160;
    localparam int T23_LO    = 62;
    localparam int T23_HI    = 72;

    localparam logic [1:0] CMD_TAP    = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;

    localparam logic [3:0] VERD_NOLOCK    = 4'd0;
    localparam logic [3:0] VERD_KEEP      = 4'd1;
    localparam logic [3:0] VERD_MATCH     = 4'd2;
    localparam logic [3:0] VERD_X2        = 4'd3;
    localparam logic [3:0] VERD_H2        = 4'd4;
    localparam logic [3:0] VERD_X4        = 4'd5;
    localparam logic [3:0] VERD_H4        = 4'd6;
    localparam logic [3:0] VERD_T32       = 4'd7;
    localparam logic [3:0] VERD_T23       = 4'd8;
    localparam logic [3:0] VERD_UNRELATED = 4'd9;

    localparam logic [1:0] SCAT_NONE   = 2'd0;
    localparam logic [1:0] SCAT_LOOSE  = 2'd1;
    localparam logic [1:0] SCAT_STEADY = 2'd2;

    typedef enum logic [1:0] {
        DIV_FOLD  = 2'd0,
        DIV_RATIO = 2'd1,
        DIV_MEAN  = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     commit;
        logic     gath_step;
        logic     cand_rd;
        logic     cand_load;
        logic     scan_step;
        logic     pct_load;
        logic     mean_load;
        logic     out_load;
    } ctrl_t;

    typedef struct packed {
        logic fold_need;
        logic ratio_need;
        logic mean_need;
        logic div_busy;
        logic gath_done;
        logic n_zero;
        logic scan_last;
        logic found;
        logic out_free;
    } sts_t;

endpackage

[hdl/tap_tempo_phase_analyser_core.sv]
// channel | dir | beat contents
// s_      | in  | tuser: command; tdata: tap, ref beat, ref valid, lock, tracker/game period
// m_      | out | tdata: count, median, ratio, verdict, phase mean/spread/drift, scatter
//
// one command at a time; a beat runs a phase fold when needed, then a median search
// over the accepted gaps, then the ratio and mean divides where needed (shared radix-2
// divider); the median is found by rank counting through the gap memory
// reset clears tap count, write slot and control; tap memories hold no reset
// a finished result waits for the output register to be free, then moves into it;
// the next beat is taken once the result has moved into it, even while m_tready is low
module tap_tempo_phase_analyser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] command
    input  logic [1:0]  s_tuser,
    // [31:0] tap_time_ms, [63:32] ref_beat_ms, [64] ref_valid, [65] tracker_locked,
    // [77:66] tracker_period_ms, [89:78] game_period_ms, rest zero
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] tap_count, [17:6] median_period_ms, [29:18] ratio_percent, [33:30] verdict,
    // [45:34] phase_mean_ms, [57:46] phase_spread_ms, [70:58] phase_drift_ms,
    // [72:71] scatter_class, rest zero
    output logic [79:0] m_tdata
);

    // command and status between sequencer and datapath
    ttpa_pkg::ctrl_t ctrl;
    ttpa_pkg::sts_t  sts;

    ttpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctrl     (ctrl)
    );

    ttpa_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .sts      (sts),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[hdl/ttpa_div.sv]
module ttpa_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ttpa_pkg::DIV_W-1:0]   dividend,
    input  logic [11:0]                  divisor,
    output logic                         busy,
    output logic [ttpa_pkg::DIV_W-1:0]   quo,
    output logic [11:0]                  rem
);

    logic                          busy_reg, busy_next;
    logic [ttpa_pkg::DIV_CW-1:0]   cnt_reg, cnt_next;
    logic [ttpa_pkg::DIV_W-1:0]    quo_reg, quo_next;
    logic [11:0]                   rem_reg, rem_next;
    logic [11:0]                   dvs_reg, dvs_next;
    logic [12:0]                   part;
    logic [12:0]                   diff;

    assign part = {rem_reg, quo_reg[ttpa_pkg::DIV_W-1]};
    assign diff = part - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // one restoring step per cycle
            if (!diff[12]) begin
                rem_next = diff[11:0];
                quo_next = {quo_reg[ttpa_pkg::DIV_W-2:0], 1'b1};
            end else begin
                rem_next = part[11:0];
                quo_next = {quo_reg[ttpa_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ttpa_pkg::DIV_CW'(ttpa_pkg::DIV_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

[hdl/ttpa_dp.sv]
module ttpa_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ttpa_pkg::ctrl_t      ctrl,
    output ttpa_pkg::sts_t       sts,
    input  logic [1:0]           s_tuser,
    input  logic [95:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [79:0]          m_tdata
);

    localparam int IW = ttpa_pkg::IW;
    localparam int CW = ttpa_pkg::CW;
    localparam int SW = ttpa_pkg::SW;

    // latched command
    logic [1:0]  cmd_reg;
    logic [31:0] at_reg, ref_reg;
    logic        rvalid_reg, locked_reg;
    logic [11:0] tper_reg, gper_reg;

    // ring state
    logic [CW-1:0] held_reg, held_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [31:0]   times_mem [ttpa_pkg::TAP_DEPTH];
    logic [11:0]   errs_mem  [ttpa_pkg::TAP_DEPTH];
    logic [31:0]   t_q;
    logic [11:0]   e_q;

    // gather pass
    logic [CW-1:0]  gi_reg;
    logic [IW-1:0]  idx;
    logic [IW:0]    idx_sum;
    logic [31:0]    prev_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [11:0] lo_reg, hi_reg, first_reg, last_reg;
    logic [IW-1:0]  n_reg;
    logic [11:0]    gap_mem [ttpa_pkg::GAP_DEPTH];
    logic [11:0]    gap_q;
    logic [IW-1:0]  gap_raddr;
    logic [31:0]    gap_d;
    logic           gap_ok;

    // median search
    logic [IW-1:0] j_reg, k_reg, cc_reg, lt_reg, le_reg;
    logic [IW-1:0] lt_n, le_n, half;
    logic [11:0]   cand_reg, med_reg;
    logic          pend_reg, found_reg;

    // results
    logic [11:0] pct_reg;
    logic signed [11:0] mean_reg;
    logic        ovalid_reg;
    logic [79:0] odata_reg;

    // divider hookup
    logic [31:0] d_diff, d_mag, div_a, div_q;
    logic [11:0] div_b, div_r;
    logic        div_busy;
    logic [SW-1:0] sum_mag;
    logic [12:0] r_fold, err13;
    logic [11:0] err_w;

    assign d_diff = at_reg - ref_reg;
    assign d_mag  = d_diff[31] ? (32'd0 - d_diff) : d_diff;
    assign sum_mag = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);

    always_comb begin
        unique case (ctrl.div_sel)
            ttpa_pkg::DIV_FOLD: begin
                div_a = d_mag;
                div_b = tper_reg;
            end
            ttpa_pkg::DIV_RATIO: begin
                div_a = 32'(gper_reg) * 32'(ttpa_pkg::PCT_SCALE);
                div_b = med_reg;
            end
            ttpa_pkg::DIV_MEAN: begin
                div_a = 32'(sum_mag);
                div_b = 12'(held_reg);
            end
            default: begin
                div_a = '0;
                div_b = '0;
            end
        endcase
    end

    ttpa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quo      (div_q),
        .rem      (div_r)
    );

    // residue folded into plus or minus half a period
    always_comb begin
        r_fold = (d_diff[31] && (div_r != 12'd0)) ? {1'b0, tper_reg - div_r} : {1'b0, div_r};
        if (r_fold > {2'b00, tper_reg[11:1]}) begin
            err13 = r_fold - {1'b0, tper_reg};
        end else begin
            err13 = r_fold;
        end
        err_w = sts.fold_need ? err13[11:0] : 12'd0;
    end

    // ring order: oldest first
    always_comb begin
        if (held_reg < CW'(ttpa_pkg::TAP_DEPTH)) begin
            idx_sum = {1'b0, gi_reg[IW-1:0]};
        end else begin
            idx_sum = {1'b0, slot_reg} + {1'b0, gi_reg[IW-1:0]};
        end
        if (idx_sum >= (IW+1)'(ttpa_pkg::TAP_DEPTH)) begin
            idx = IW'(idx_sum - (IW+1)'(ttpa_pkg::TAP_DEPTH));
        end else begin
            idx = idx_sum[IW-1:0];
        end
    end

    assign gap_d  = t_q - prev_reg;
    assign gap_ok = (gi_reg != '0) && !gap_d[31] && (gap_d > 32'(ttpa_pkg::GAP_MIN))
                    && (gap_d < 32'(ttpa_pkg::GAP_MAX));

    assign gap_raddr = ctrl.cand_rd ? j_reg : k_reg;
    assign half = n_reg >> 1;
    assign lt_n = lt_reg + IW'(gap_q < cand_reg);
    assign le_n = le_reg + IW'(gap_q <= cand_reg);

    always_comb begin
        held_next = held_reg;
        slot_next = slot_reg;
        if (ctrl.commit) begin
            if (cmd_reg == ttpa_pkg::CMD_TAP) begin
                slot_next = (slot_reg == IW'(ttpa_pkg::TAP_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                if (held_reg < CW'(ttpa_pkg::TAP_DEPTH)) begin
                    held_next = held_reg + 1'b1;
                end
            end else if (cmd_reg == ttpa_pkg::CMD_CLEAR) begin
                held_next = '0;
                slot_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit && (cmd_reg == ttpa_pkg::CMD_TAP)) begin
            times_mem[slot_reg] <= at_reg;
            errs_mem[slot_reg]  <= err_w;
        end
        t_q <= times_mem[idx];
        e_q <= errs_mem[idx];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.gath_step && gap_ok) begin
            gap_mem[n_reg] <= gap_d[11:0];
        end
        gap_q <= gap_mem[gap_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg   <= '0;
            slot_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            held_reg <= held_next;
            slot_reg <= slot_next;
            if (ctrl.out_load) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    function automatic logic [3:0] verdict_of(input logic [11:0] p, input logic lk);
        logic [3:0] v;
        if (!lk) v = ttpa_pkg::VERD_NOLOCK;
        else if (p == 12'd0) v = ttpa_pkg::VERD_KEEP;
        else if (p >= 12'(ttpa_pkg::MATCH_LO) && p <= 12'(ttpa_pkg::MATCH_HI))
            v = ttpa_pkg::VERD_MATCH;
        else if (p >= 12'(ttpa_pkg::X2_LO) && p <= 12'(ttpa_pkg::X2_HI)) v = ttpa_pkg::VERD_X2;
        else if (p >= 12'(ttpa_pkg::H2_LO) && p <= 12'(ttpa_pkg::H2_HI)) v = ttpa_pkg::VERD_H2;
        else if (p >= 12'(ttpa_pkg::X4_LO) && p <= 12'(ttpa_pkg::X4_HI)) v = ttpa_pkg::VERD_X4;
        else if (p >= 12'(ttpa_pkg::H4_LO) && p <= 12'(ttpa_pkg::H4_HI)) v = ttpa_pkg::VERD_H4;
        else if (p >= 12'(ttpa_pkg::T32_LO) && p <= 12'(ttpa_pkg::T32_HI))
            v = ttpa_pkg::VERD_T32;
        else if (p >= 12'(ttpa_pkg::T23_LO) && p <= 12'(ttpa_pkg::T23_HI))
            v = ttpa_pkg::VERD_T23;
        else v = ttpa_pkg::VERD_UNRELATED;
        return v;
    endfunction

    function automatic logic [79:0] out_pack();
        logic        many;
        logic [11:0] spread;
        logic [12:0] drift;
        logic [13:0] spread3;
        logic [1:0]  scat;
        many    = (held_reg >= CW'(2));
        spread  = many ? 12'(hi_reg - lo_reg) : 12'd0;
        drift   = many ? (13'(last_reg) - 13'(first_reg)) : 13'd0;
        spread3 = 14'(spread) * 14'd3;
        if (spread3 > 14'(tper_reg)) scat = ttpa_pkg::SCAT_LOOSE;
        else if (held_reg > CW'(3)) scat = ttpa_pkg::SCAT_STEADY;
        else scat = ttpa_pkg::SCAT_NONE;
        return {7'd0, scat, drift, spread, mean_reg, verdict_of(pct_reg, locked_reg),
                pct_reg, med_reg, 6'(held_reg)};
    endfunction

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg    <= s_tuser;
            at_reg     <= s_tdata[31:0];
            ref_reg    <= s_tdata[63:32];
            rvalid_reg <= s_tdata[64];
            locked_reg <= s_tdata[65];
            tper_reg   <= s_tdata[77:66];
            gper_reg   <= s_tdata[89:78];
            pct_reg    <= '0;
            mean_reg   <= '0;
        end
        if (ctrl.commit) begin
            gi_reg    <= '0;
            n_reg     <= '0;
            j_reg     <= '0;
            found_reg <= 1'b0;
            med_reg   <= '0;
        end
        if (ctrl.gath_step) begin
            if (gi_reg == '0) begin
                sum_reg   <= SW'(signed'(e_q));
                lo_reg    <= e_q;
                hi_reg    <= e_q;
                first_reg <= e_q;
            end else begin
                sum_reg <= sum_reg + SW'(signed'(e_q));
                if (signed'(e_q) < lo_reg) lo_reg <= e_q;
                if (signed'(e_q) > hi_reg) hi_reg <= e_q;
            end
            last_reg <= e_q;
            prev_reg <= t_q;
            gi_reg   <= gi_reg + 1'b1;
            if (gap_ok) begin
                n_reg <= n_reg + 1'b1;
            end
        end
        if (ctrl.cand_load) begin
            cand_reg <= gap_q;
            lt_reg   <= '0;
            le_reg   <= '0;
            k_reg    <= '0;
            cc_reg   <= '0;
            pend_reg <= 1'b0;
        end
        if (ctrl.scan_step) begin
            pend_reg <= (k_reg < n_reg);
            if (k_reg < n_reg) begin
                k_reg <= k_reg + 1'b1;
            end
            if (pend_reg) begin
                lt_reg <= lt_n;
                le_reg <= le_n;
                cc_reg <= cc_reg + 1'b1;
                if (sts.scan_last) begin
                    if ((lt_n <= half) && (half < le_n)) begin
                        med_reg   <= cand_reg;
                        found_reg <= 1'b1;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
            end
        end
        if (ctrl.pct_load) begin
            pct_reg <= div_q[11:0];
        end
        if (ctrl.mean_load) begin
            mean_reg <= sum_reg[SW-1] ? 12'(32'd0 - div_q) : div_q[11:0];
        end
        if (ctrl.out_load) begin
            odata_reg <= out_pack();
        end
    end

    assign sts.fold_need  = (cmd_reg == ttpa_pkg::CMD_TAP) && locked_reg && rvalid_reg
                            && (tper_reg != 12'd0);
    assign sts.ratio_need = (gper_reg != 12'd0) && (med_reg != 12'd0);
    assign sts.mean_need  = (held_reg >= CW'(2));
    assign sts.div_busy   = div_busy;
    assign sts.gath_done  = (gi_reg == held_reg);
    assign sts.n_zero     = (n_reg == '0);
    assign sts.scan_last  = pend_reg && (cc_reg == n_reg - 1'b1);
    assign sts.found      = found_reg;
    assign sts.out_free   = !ovalid_reg || m_tready;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

endmodule

[hdl/ttpa_ctrl.sv]
module ttpa_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  ttpa_pkg::sts_t  sts,
    output ttpa_pkg::ctrl_t ctrl
);

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_START  = 14'b00000000000010,
        ST_FGO    = 14'b00000000000100,
        ST_FWAIT  = 14'b00000000001000,
        ST_COMMIT = 14'b00000000010000,
        ST_GRD    = 14'b00000000100000,
        ST_GUSE   = 14'b00000001000000,
        ST_CRD    = 14'b00000010000000,
        ST_CUSE   = 14'b00000100000000,
        ST_SCAN   = 14'b00001000000000,
        ST_EVAL   = 14'b00010000000000,
        ST_RGO    = 14'b00100000000000,
        ST_RWAIT  = 14'b01000000000000,
        ST_MEAN   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   mwait_reg, mwait_next;
    logic   fin_reg, fin_next;

    always_comb begin
        state_next = state_reg;
        mwait_next = mwait_reg;
        fin_next   = fin_reg;
        ctrl       = '0;
        ctrl.div_sel = ttpa_pkg::DIV_FOLD;
        unique case (state_reg)
            ST_IDLE: begin
                if (fin_reg) begin
                    if (sts.out_free) begin
                        ctrl.out_load = 1'b1;
                        fin_next      = 1'b0;
                    end
                end else if (s_tvalid) begin
                    ctrl.load  = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: state_next = sts.fold_need ? ST_FGO : ST_COMMIT;
            ST_FGO: begin
                ctrl.div_start = 1'b1;
                state_next     = ST_FWAIT;
            end
            ST_FWAIT: if (!sts.div_busy) state_next = ST_COMMIT;
            ST_COMMIT: begin
                ctrl.commit = 1'b1;
                state_next  = ST_GRD;
            end
            ST_GRD: begin
                if (sts.gath_done) begin
                    state_next = sts.n_zero ? ST_RGO : ST_CRD;
                end else begin
                    state_next = ST_GUSE;
                end
            end
            ST_GUSE: begin
                ctrl.gath_step = 1'b1;
                state_next     = ST_GRD;
            end
            ST_CRD: begin
                ctrl.cand_rd = 1'b1;
                state_next   = ST_CUSE;
            end
            ST_CUSE: begin
                ctrl.cand_load = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                ctrl.scan_step = 1'b1;
                if (sts.scan_last) state_next = ST_EVAL;
            end
            ST_EVAL: state_next = sts.found ? ST_RGO : ST_CRD;
            ST_RGO: begin
                ctrl.div_sel = ttpa_pkg::DIV_RATIO;
                if (sts.ratio_need) begin
                    ctrl.div_start = 1'b1;
                    state_next     = ST_RWAIT;
                end else begin
                    state_next = ST_MEAN;
                end
                mwait_next = 1'b0;
            end
            ST_RWAIT: begin
                ctrl.div_sel = ttpa_pkg::DIV_RATIO;
                if (!sts.div_busy) begin
                    ctrl.pct_load = 1'b1;
                    state_next    = ST_MEAN;
                end
            end
            ST_MEAN: begin
                // on entry starts the divider, then waits for it; with fewer than two taps it skips the divide
                ctrl.div_sel = ttpa_pkg::DIV_MEAN;
                if (!mwait_reg) begin
                    if (sts.mean_need) begin
                        ctrl.div_start = 1'b1;
                        mwait_next     = 1'b1;
                    end else begin
                        fin_next   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (!sts.div_busy) begin
                    ctrl.mean_load = 1'b1;
                    mwait_next     = 1'b0;
                    fin_next       = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mwait_reg <= 1'b0;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            mwait_reg <= mwait_next;
            fin_reg   <= fin_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !fin_reg;

endmodule
